// ===== design/indexed_min_heap_unit_macros.svh =====
// assertion macros for the indexed min-heap unit
// used by the top level only
`ifndef INDEXED_MIN_HEAP_UNIT_MACROS_SVH
`define INDEXED_MIN_HEAP_UNIT_MACROS_SVH
// implication checked at every edge outside reset
`define IMH_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication checked outside reset
`define IMH_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== design/imh_pkg.sv =====
// shared types and constants for the indexed min-heap unit
// no dependencies
`default_nettype none
package imh_pkg;
    localparam int ID_BITS = 10;
    localparam int ID_SPACE = 1 << ID_BITS;

    typedef enum logic [1:0] {
        K_INSERT  = 2'd0,
        K_EXTRACT = 2'd1,
        K_CHANGE  = 2'd2,
        K_NONE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        E_OK      = 2'd0,
        E_FULL    = 2'd1,
        E_ABSENT  = 2'd2,
        E_PRESENT = 2'd3
    } t_err;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_MAPRD, S_DECODE,
        S_INS_WR, S_UP_RD, S_UP_CMP,
        S_EX_RD, S_EX_WR, S_EX_PUT,
        S_CH_RD, S_CH_DEC,
        S_DN_RD, S_DN_RD2, S_DN_CMP,
        S_SW_WR2,
        S_TOP_RD, S_TOP_LAT, S_DONE
    } t_state;
endpackage
`default_nettype wire

// ===== design/imh_ram.sv =====
// generic single-port ram with registered read
// no dependencies
`default_nettype none
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== design/imh_front.sv =====
// input skid queue: two-entry fifo of commands in front of the heap engine
// depends on imh_pkg
`default_nettype none
module imh_front
    import imh_pkg::*;
#(
    parameter int KEY_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [1:0]          i_kind,
    input  wire logic [ID_BITS-1:0]  i_id,
    input  wire logic [KEY_BITS-1:0] i_key,
    output logic                     o_valid,
    input  wire logic                i_take,
    output t_kind                    o_kind,
    output logic [ID_BITS-1:0]       o_id,
    output logic [KEY_BITS-1:0]      o_key
);
    localparam int W = 2 + ID_BITS + KEY_BITS;
    logic [W-1:0] r_q [2];
    logic [1:0]   r_cnt;
    logic         r_rd, r_wr;
    logic         push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_take;
    assign o_kind  = t_kind'(r_q[r_rd][W-1 -: 2]);
    assign o_id    = r_q[r_rd][KEY_BITS +: ID_BITS];
    assign o_key   = r_q[r_rd][KEY_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= {i_kind, i_id, i_key};
        end
    end
endmodule
`default_nettype wire

// ===== design/imh_engine.sv =====
// heap engine: sequencer over key, id and position-map memories
// depends on imh_pkg and imh_ram
`default_nettype none
module imh_engine
    import imh_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_take,
    input  wire t_kind               i_kind,
    input  wire logic [ID_BITS-1:0]  i_id,
    input  wire logic [KEY_BITS-1:0] i_key,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [ID_BITS-1:0]       o_taken_id,
    output logic [31:0]              o_taken_key,
    output logic [ID_BITS-1:0]       o_top_id,
    output logic [31:0]              o_top_key,
    output logic                     o_not_empty,
    output logic [10:0]              o_entry_count,
    output logic [1:0]               o_error_code,
    output logic                     o_busy
);
    localparam int SB = $clog2(CAPACITY + 1);   // slot number bits (1..CAPACITY)
    localparam int AB = $clog2(CAPACITY);       // heap memory address bits

    t_state r_st, n_st;
    logic [SB-1:0]       r_fill, r_s, r_c, r_m, r_last;
    logic [KEY_BITS-1:0] r_k, r_ka, r_kb, r_old;
    logic [ID_BITS-1:0]  r_i, r_ia;
    t_kind               r_kind;
    t_err                r_err;
    logic                r_lmin;
    logic [ID_BITS-1:0]  r_tid;
    logic [KEY_BITS-1:0] r_tkey;
    logic [ID_BITS-1:0]  r_oid;
    logic [KEY_BITS-1:0] r_okey;
    logic                r_ov;
    logic [ID_BITS-1:0]  r_clr;

    // heap memory port
    logic                h_we;
    logic [SB-1:0]       h_slot;
    logic [KEY_BITS-1:0] h_wk, h_rk;
    logic [ID_BITS-1:0]  h_wi, h_ri;
    // position map port
    logic                m_we;
    logic [ID_BITS-1:0]  m_addr;
    logic [SB-1:0]       m_wd, m_rd;

    imh_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_keys (
        .i_clk, .i_we(h_we), .i_addr(AB'(h_slot - 1'b1)), .i_wdata(h_wk), .o_rdata(h_rk));
    imh_ram #(.WIDTH(ID_BITS), .DEPTH(CAPACITY)) u_ids (
        .i_clk, .i_we(h_we), .i_addr(AB'(h_slot - 1'b1)), .i_wdata(h_wi), .o_rdata(h_ri));
    imh_ram #(.WIDTH(SB), .DEPTH(ID_SPACE)) u_map (
        .i_clk, .i_we(m_we), .i_addr(m_addr), .i_wdata(m_wd), .o_rdata(m_rd));

    logic up_above, dn_lt, dn_right, dn_move, up_dir;
    assign up_above = (h_rk > r_k) || (h_rk == r_k && h_ri > r_i);
    assign dn_lt    = h_rk < r_k;
    // right child compare happens on the data returned after S_DN_RD2
    assign dn_right = ({1'b0, r_s, 1'b1} <= {2'b0, r_fill}) && (h_rk < r_kb);
    assign dn_move  = dn_right || r_lmin;
    assign up_dir   = (r_kind == K_INSERT) || (r_kind == K_CHANGE && r_k < r_old);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_CLEAR:   n_st = (r_clr == '1) ? S_IDLE : S_CLEAR;
            S_IDLE:    if (i_valid) n_st = S_MAPRD;
            S_MAPRD:   n_st = S_DECODE;
            S_DECODE: begin
                priority case (r_kind)
                    K_INSERT:  n_st = (m_rd != '0 || r_fill == SB'(CAPACITY)) ? S_TOP_RD
                                                                               : S_INS_WR;
                    K_EXTRACT: n_st = (r_fill == '0) ? S_TOP_RD : S_EX_RD;
                    K_CHANGE:  n_st = (m_rd == '0 || m_rd > r_fill) ? S_TOP_RD : S_CH_RD;
                    default:   n_st = S_TOP_RD;
                endcase
            end
            S_INS_WR:  n_st = (r_s > SB'(1)) ? S_UP_RD : S_TOP_RD;
            S_UP_RD:   n_st = S_UP_CMP;
            S_UP_CMP:  n_st = up_above ? S_SW_WR2 : S_TOP_RD;
            S_EX_RD:   n_st = S_EX_WR;
            S_EX_WR:   n_st = (r_fill > SB'(1)) ? S_EX_PUT : S_TOP_RD;
            S_EX_PUT:  n_st = S_DN_RD;
            S_CH_RD:   n_st = S_CH_DEC;
            S_CH_DEC:  n_st = (r_k < h_rk) ? ((r_s > SB'(1)) ? S_UP_RD : S_TOP_RD) : S_DN_RD;
            S_DN_RD:   n_st = ({r_s, 1'b0} <= {1'b0, r_fill}) ? S_DN_RD2 : S_TOP_RD;
            S_DN_RD2:  n_st = S_DN_CMP;
            S_DN_CMP:  n_st = dn_move ? S_SW_WR2 : S_TOP_RD;
            S_SW_WR2:  n_st = up_dir ? ((r_m > SB'(1)) ? S_UP_RD : S_TOP_RD) : S_DN_RD;
            S_TOP_RD:  n_st = S_TOP_LAT;
            S_TOP_LAT: n_st = S_DONE;
            S_DONE:    if (!r_ov) n_st = S_IDLE;
            default:   n_st = S_IDLE;
        endcase
    end

    // sequencer datapath; sift loops return through r_st
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_CLEAR;
            r_clr  <= '0;
            r_fill <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: if (i_valid) begin
                    r_kind <= i_kind; r_i <= i_id; r_k <= i_key;
                    r_err <= E_OK; r_tid <= '0; r_tkey <= '0;
                end
                S_DECODE: begin
                    priority case (r_kind)
                        K_INSERT: begin
                            if (m_rd != '0) r_err <= E_PRESENT;
                            else if (r_fill == SB'(CAPACITY)) r_err <= E_FULL;
                            else begin
                                r_fill <= r_fill + 1'b1;
                                r_s    <= r_fill + 1'b1;
                            end
                        end
                        K_EXTRACT: if (r_fill == '0) r_err <= E_FULL;
                        K_CHANGE: begin
                            if (m_rd == '0 || m_rd > r_fill) r_err <= E_ABSENT;
                            r_s <= m_rd;
                        end
                        default: ;
                    endcase
                end
                S_INS_WR: ;
                S_UP_RD: r_c <= r_s >> 1;
                S_UP_CMP: if (up_above) begin
                    r_ka <= h_rk; r_ia <= h_ri; r_m <= r_c;
                end
                S_EX_RD: r_last <= r_fill;
                S_EX_WR: begin
                    r_tid <= h_ri; r_tkey <= h_rk;
                    r_fill <= r_fill - 1'b1;
                end
                S_EX_PUT: begin
                    r_k <= h_rk; r_i <= h_ri; r_s <= SB'(1);
                end
                S_CH_RD: ;
                S_CH_DEC: r_old <= h_rk;
                S_DN_RD: begin
                    r_m <= r_s; r_lmin <= 1'b0; r_kb <= r_k;
                end
                S_DN_RD2: if (dn_lt) begin
                    r_m <= {r_s[SB-2:0], 1'b0}; r_ka <= h_rk; r_ia <= h_ri; r_kb <= h_rk;
                    r_lmin <= 1'b1;
                end
                S_DN_CMP: if (dn_right) begin
                    r_m <= {r_s[SB-2:0], 1'b1}; r_ka <= h_rk; r_ia <= h_ri;
                end
                S_SW_WR2: r_s <= r_m;
                S_TOP_RD: ;
                S_TOP_LAT: begin
                    r_oid  <= (r_fill != '0) ? h_ri : '0;
                    r_okey <= (r_fill != '0) ? h_rk : '0;
                    r_ov   <= 1'b1;
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    // memory port drive per state
    always_comb begin
        h_we = 1'b0; h_slot = r_s; h_wk = r_k; h_wi = r_i;
        m_we = 1'b0; m_addr = r_i; m_wd = r_s;
        unique case (r_st)
            S_CLEAR: begin m_we = 1'b1; m_addr = r_clr; m_wd = '0; end
            S_IDLE:   m_addr = i_id;
            S_INS_WR: begin h_we = 1'b1; m_we = 1'b1; end
            S_UP_RD:  h_slot = r_s >> 1;
            S_UP_CMP: if (up_above) begin
                // parent moves down into current slot
                h_we = 1'b1; h_wk = h_rk; h_wi = h_ri;
                m_we = 1'b1; m_addr = h_ri; m_wd = r_s;
            end
            S_EX_RD:  h_slot = SB'(1);
            S_EX_WR: begin
                // top beat is on the read port, fetch the last entry
                h_slot = r_last;
                m_we = 1'b1; m_addr = h_ri; m_wd = '0;
            end
            S_EX_PUT: begin
                h_we = 1'b1; h_slot = SB'(1); h_wk = h_rk; h_wi = h_ri;
                m_we = 1'b1; m_addr = h_ri; m_wd = SB'(1);
            end
            S_CH_RD:  h_slot = r_s;
            S_CH_DEC: h_we = 1'b1;
            S_DN_RD:  h_slot = {r_s[SB-2:0], 1'b0};
            S_DN_RD2: h_slot = {r_s[SB-2:0], 1'b1};
            S_DN_CMP: begin
                h_slot = r_s;
                if (dn_move) begin
                    h_we = 1'b1;
                    m_we = 1'b1;
                    if (dn_right) begin
                        h_wk = h_rk; h_wi = h_ri; m_addr = h_ri;
                    end else begin
                        h_wk = r_ka; h_wi = r_ia; m_addr = r_ia;
                    end
                end
            end
            S_SW_WR2: begin
                // moving entry lands in the vacated slot
                h_we = 1'b1; h_slot = r_m; m_we = 1'b1; m_wd = r_m;
            end
            S_TOP_RD: h_slot = SB'(1);
            default: ;
        endcase
    end

    assign o_take        = (r_st == S_IDLE);
    assign o_valid       = r_ov;
    assign o_taken_id    = r_tid;
    assign o_taken_key   = 32'(r_tkey);
    assign o_top_id      = r_oid;
    assign o_top_key     = 32'(r_okey);
    assign o_not_empty   = (r_fill != '0);
    assign o_entry_count = 11'(r_fill);
    assign o_error_code  = r_err;
    assign o_busy        = (r_st != S_IDLE);
endmodule
`default_nettype wire

// ===== design/indexed_min_heap_unit.sv =====
// top level of the indexed min-heap unit: command queue and heap engine
// depends on imh_pkg, imh_front, imh_engine and the macros header
`default_nettype none
`include "indexed_min_heap_unit_macros.svh"
// Indexed binary min-heap of (key, id) pairs with a position map, one result
// beat per command beat. After reset the 1024 entries of the position map are
// cleared, during which no command is taken. A command that changes nothing
// goes straight to the read of the top; an insert climbs from the new last
// slot, a change key climbs or sinks from its slot, and an extract moves the
// last entry to the top and sinks it. The single port of the heap memories
// carries one read or write per cycle and so sets the pace of every command.
// A two-beat queue takes commands while the engine works; the result beat is
// held until taken and the engine waits for it.
module indexed_min_heap_unit
    import imh_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // item_id[9:0], new_key[41:10], zero pad
    input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [103:0]     m_axis_tdata    // taken_id, taken_key, top_id, top_key,
                                             // not_empty, entry_count, error_code, pad
);
    logic                valid_q, take_q, busy;
    t_kind               kind_q;
    logic [ID_BITS-1:0]  id_q;
    logic [KEY_BITS-1:0] key_q;
    logic [ID_BITS-1:0]  taken_id, top_id;
    logic [31:0]         taken_key, top_key;
    logic                not_empty;
    logic [10:0]         entry_count;
    logic [1:0]          error_code;

    imh_front #(.KEY_BITS(KEY_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_kind(s_axis_tuser), .i_id(s_axis_tdata[9:0]),
        .i_key(KEY_BITS'(s_axis_tdata[41:10])),
        .o_valid(valid_q), .i_take(take_q),
        .o_kind(kind_q), .o_id(id_q), .o_key(key_q));

    imh_engine #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_engine (
        .i_clk, .i_rst_n,
        .i_valid(valid_q), .o_take(take_q),
        .i_kind(kind_q), .i_id(id_q), .i_key(key_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_taken_id(taken_id), .o_taken_key(taken_key),
        .o_top_id(top_id), .o_top_key(top_key),
        .o_not_empty(not_empty), .o_entry_count(entry_count),
        .o_error_code(error_code), .o_busy(busy));

    assign m_axis_tdata = {6'd0, error_code, entry_count, not_empty,
                           top_key, top_id, taken_key, taken_id};

    `IMH_ASSERT_IMP(a_out_not_idle, i_clk, i_rst_n, m_axis_tvalid, busy,
        "result shown while engine idle")
    `IMH_ASSERT_IMP(a_empty_top, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[84],
        m_axis_tdata[51:42] == 10'd0 && m_axis_tdata[95:85] == 11'd0, "empty heap reports top")
    `IMH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid, "result dropped before taken")
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for indexed_min_heap_unit: streams heap commands
// and compares every result beat with an in-bench model; depends on imh_pkg
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import imh_pkg::*;

    typedef struct packed {
        logic [9:0]  taken_id;
        logic [31:0] taken_key;
        logic [9:0]  top_id;
        logic [31:0] top_key;
        logic        not_empty;
        logic [10:0] entry_count;
        t_err        error_code;
    } t_status;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [47:0]   s_axis_tdata = '0;
    logic [1:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [103:0]  m_axis_tdata;

    indexed_min_heap_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // heap image kept by the bench, slots 1..heap_fill
    logic [31:0] heap_key [1:1024];
    logic [9:0]  heap_id  [1:1024];
    logic [10:0] id_slot  [0:1023];
    int unsigned heap_fill;

    t_status     pending_status [$];
    int unsigned errors = 0;
    int unsigned beats_sent = 0;
    int unsigned beats_seen = 0;
    int unsigned deepest = 0;
    int unsigned cycles = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;

    task automatic place(input int unsigned s, input logic [31:0] k, input logic [9:0] id);
        heap_key[s] = k;
        heap_id[s] = id;
        id_slot[id] = s[10:0];
    endtask

    task automatic swap_slots(input int unsigned a, input int unsigned b);
        logic [31:0] k;
        logic [9:0]  id;
        k = heap_key[a];
        id = heap_id[a];
        place(a, heap_key[b], heap_id[b]);
        place(b, k, id);
    endtask

    task automatic climb(input int unsigned s);
        int unsigned p;
        while (s > 1) begin
            p = s / 2;
            if (!(heap_key[p] > heap_key[s] ||
                  (heap_key[p] == heap_key[s] && heap_id[p] > heap_id[s])))
                break;
            swap_slots(p, s);
            s = p;
        end
    endtask

    task automatic sink(input int unsigned s);
        int unsigned m;
        forever begin
            m = s;
            if (2*s <= heap_fill && heap_key[2*s] < heap_key[m]) m = 2*s;
            if (2*s+1 <= heap_fill && heap_key[2*s+1] < heap_key[m]) m = 2*s+1;
            if (m == s) break;
            swap_slots(m, s);
            s = m;
        end
    endtask

    task automatic heap_apply(input t_kind kind, input logic [9:0] id, input logic [31:0] k);
        t_status     st;
        int unsigned s;
        logic [31:0] old;
        st = '0;
        st.error_code = E_OK;
        case (kind)
            K_INSERT: begin
                if (id_slot[id] != 0) st.error_code = E_PRESENT;
                else if (heap_fill >= 1024) st.error_code = E_FULL;
                else begin
                    heap_fill++;
                    place(heap_fill, k, id);
                    climb(heap_fill);
                end
            end
            K_EXTRACT: begin
                if (heap_fill == 0) st.error_code = E_FULL;
                else begin
                    st.taken_id = heap_id[1];
                    st.taken_key = heap_key[1];
                    id_slot[heap_id[1]] = 0;
                    if (heap_fill > 1) place(1, heap_key[heap_fill], heap_id[heap_fill]);
                    heap_fill--;
                    if (heap_fill > 0) sink(1);
                end
            end
            K_CHANGE: begin
                s = id_slot[id];
                if (s == 0 || s > heap_fill) st.error_code = E_ABSENT;
                else begin
                    old = heap_key[s];
                    heap_key[s] = k;
                    if (k < old) climb(s);
                    else sink(s);
                end
            end
            default: ;
        endcase
        if (heap_fill > 0) begin
            st.top_id = heap_id[1];
            st.top_key = heap_key[1];
            st.not_empty = 1'b1;
        end
        st.entry_count = heap_fill[10:0];
        if (heap_fill > deepest) deepest = heap_fill;
        pending_status = {pending_status, st};
    endtask

    // one command beat, with an optional random gap in front of it
    task automatic send_cmd(input t_kind kind, input logic [9:0] id, input logic [31:0] k);
        int unsigned gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, k, id};
        s_axis_tuser <= kind;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        heap_apply(kind, id, k);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        int unsigned n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                for (n = 0; n < 400; n++) @(negedge i_clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 3);
                repeat (n) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_status got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.taken_id    = m_axis_tdata[9:0];
            got.taken_key   = m_axis_tdata[41:10];
            got.top_id      = m_axis_tdata[51:42];
            got.top_key     = m_axis_tdata[83:52];
            got.not_empty   = m_axis_tdata[84];
            got.entry_count = m_axis_tdata[95:85];
            got.error_code  = t_err'(m_axis_tdata[97:96]);
            beats_seen++;
            if (pending_status.size() == 0) begin
                $display("%0t unexpected result beat %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = pending_status.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch: expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1000000) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [9:0] pick_id(input int unsigned pool);
        if ($urandom_range(0, 5) == 0) return 10'($urandom);
        return 10'($urandom_range(0, pool));
    endfunction

    task automatic test_directed();
        send_cmd(K_EXTRACT, 10'd0, 32'd0);            // extract from empty
        send_cmd(K_CHANGE, 10'd5, 32'd1);             // change of absent id
        send_cmd(K_NONE, 10'h3FF, 32'hFFFF_FFFF);     // unused kind on empty heap
        send_cmd(K_INSERT, 10'h3FF, 32'hFFFF_FFFF);
        send_cmd(K_INSERT, 10'd0, 32'hFFFF_FFFF);     // equal key, lower id climbs
        send_cmd(K_INSERT, 10'd0, 32'd3);             // already present
        send_cmd(K_INSERT, 10'd7, 32'd0);
        send_cmd(K_INSERT, 10'd9, 32'd0);
        send_cmd(K_INSERT, 10'h155, 32'h5555_5555);
        send_cmd(K_INSERT, 10'h2AA, 32'hAAAA_AAAA);
        send_cmd(K_NONE, 10'd0, 32'd0);
        send_cmd(K_CHANGE, 10'h3FF, 32'd0);           // decrease, held below an equal key with lower id
        send_cmd(K_CHANGE, 10'd7, 32'hFFFF_FFFF);     // increase sinks
        send_cmd(K_CHANGE, 10'h155, 32'h5555_5555);   // equal key, no move
        send_cmd(K_EXTRACT, 10'd0, 32'd0);
        send_cmd(K_CHANGE, 10'h3FF, 32'd1);           // small increase of the top, no move
        send_cmd(K_EXTRACT, 10'd0, 32'd0);
        send_cmd(K_EXTRACT, 10'd0, 32'd0);
        send_cmd(K_EXTRACT, 10'd0, 32'd0);
        send_cmd(K_EXTRACT, 10'd0, 32'd0);
        send_cmd(K_EXTRACT, 10'd0, 32'd0);
        send_cmd(K_EXTRACT, 10'd0, 32'd0);            // empty again
    endtask

    task automatic test_random_mix(input int unsigned count);
        int unsigned r;
        repeat (count) begin
            r = $urandom_range(0, 19);
            if (r < 8) send_cmd(K_INSERT, pick_id(63), pick_key());
            else if (r < 13) send_cmd(K_EXTRACT, 10'($urandom), 32'($urandom));
            else if (r < 19) send_cmd(K_CHANGE, pick_id(63), pick_key());
            else send_cmd(K_NONE, 10'($urandom), 32'($urandom));
        end
    endtask

    // deep heap; the receiver holds off at the start so the input backs up
    task automatic test_fill_deep(input int unsigned count);
        hold_req = 1'b1;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) send_cmd(K_CHANGE, 10'($urandom), pick_key());
            else send_cmd(K_INSERT, 10'($urandom), pick_key());
        end
    endtask

    task automatic test_drain(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++) begin
            if (i > count - 150) calm = 1'b1;
            if ($urandom_range(0, 3) == 0) send_cmd(K_CHANGE, 10'($urandom), pick_key());
            else send_cmd(K_EXTRACT, 10'($urandom), 32'($urandom));
        end
        while (heap_fill > 0) send_cmd(K_EXTRACT, 10'd0, 32'd0);
        send_cmd(K_EXTRACT, 10'd0, 32'd0);
    endtask

    initial begin
        int unsigned i;
        for (i = 0; i < 1024; i++) id_slot[i] = '0;
        heap_fill = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_mix(650);
        test_fill_deep(700);
        test_drain(560);
        s_axis_tvalid <= 1'b0;

        i = 0;
        while (pending_status.size() != 0 && i < 20000) begin
            @(posedge i_clk);
            i++;
        end
        repeat (100) @(posedge i_clk);
        if (pending_status.size() != 0) begin
            $display("%0t %0d results never arrived", $time, pending_status.size());
            errors++;
        end
        $display("sent %0d commands, checked %0d results, heap reached %0d entries",
                 beats_sent, beats_seen, deepest);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
